// ===== src/hsup_pkg.sv =====
// Package: shared constants, command codes and helpers for the surface height block.
`timescale 1ns / 1ps
`default_nettype none
package hsup_pkg;
   localparam int VertexDepthDefault = 32;
   localparam int MaxPolygonsDefault = 256;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_POLY  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [31:0] HEIGHT_NONE = 32'h8000_0000;
   localparam int SKIP_BIT = 29;
   localparam int TRI_BIT  = 20;

   // 10-bit signed normal component, sign extended and scaled by 8
   function automatic logic [31:0] norm8(input logic [9:0] v);
      norm8 = {{19{v[9]}}, v, 3'b000};
   endfunction
endpackage
`default_nettype wire

// ===== src/hsup_if.sv =====
// Interface: valid/ready channel carrying one payload.
`timescale 1ns / 1ps
`default_nettype none
interface hsup_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/hsup_divider.sv =====
// Divider: radix-2 signed 32-bit divide truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module hsup_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] shifted;

   // one quotient bit a cycle, restoring form on magnitudes
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[30:0], quo_ff[31]};
      trial = {1'b0, shifted} - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[31] ? (~dividend + 32'd1) : dividend;
         dvs_in = divisor[31] ? (~divisor + 32'd1) : divisor;
         neg_in = dividend[31] ^ divisor[31];
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], ~trial[32]};
         rem_in = trial[32] ? shifted : trial[31:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 32'd1) : quo_ff;
endmodule
`default_nettype wire

// ===== src/highest_surface_under_point.sv =====
// Top level: vertex memory, shared multiplier sequencer and running maximum.
// A load or query request is handled in the idle state itself. A polygon request reads
// its four vertex slots from the vertex memory, each through a read state and a capture
// state, then runs up to eight products on one shared 32x32 multiplier and a radix-2
// divide. A skipped polygon goes straight to the done state, one that is rejected or has
// a zero vertical normal leaves the products early, and one that reaches the divide waits
// for it. A last polygon's result is staged before it moves into the output register, and
// no request is taken while it is staged; the next request is taken while the result waits
// in the output register. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module highest_surface_under_point #(
   parameter int VERTEX_DEPTH = hsup_pkg::VertexDepthDefault,
   parameter int MAX_POLYGONS = hsup_pkg::MaxPolygonsDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [4:0]  req_vertex_index,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [15:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic [31:0] req_polygon_indices,
   input  wire logic [29:0] req_normal_word,
   input  wire logic        req_last_polygon,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_best_height,
   output logic             rsp_found,
   output logic [7:0]       rsp_best_position
);
   localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int CAP_I = (MAX_POLYGONS - 1 < 255) ? MAX_POLYGONS - 1 : 255;
   localparam logic [7:0] CAP = 8'(CAP_I);

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_CAP, S_O1A, S_O1B, S_DEC, S_O2A, S_O2B, S_O3A, S_O3B,
      S_NA, S_NB, S_DIV, S_WAIT, S_DONE
   } state_type;

   state_type   state_ff;
   logic [47:0] mem [VERTEX_DEPTH];
   logic [47:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic [2:0]  vi_ff;
   logic [15:0] vx_ff [4];
   logic [15:0] vz_ff [4];
   logic [15:0] vy1_ff;
   logic [3:0]  vok_ff;
   logic        vok_rd_ff;
   logic [31:0] qx_ff, qz_ff, best_ff, acc_ff, prod_ff;
   logic [7:0]  pos_ff, ord_ff;
   logic        fnd_ff;
   logic [31:0] ind_ff;
   logic [29:0] nrm_ff;
   logic        last_ff, swap_ff;
   logic        ov_ff;
   logic [31:0] ov_h;
   logic        ov_f;
   logic [7:0]  ov_p;
   logic [31:0] ma, mb;
   logic        div_start, div_done;
   logic [31:0] quo, num, hgt;
   logic [4:0]  vsel;
   logic [31:0] ax, az, bx, bz, cx, cz, v1x, v1z;
   logic [1:0]  sa, sb, sc;
   logic [31:0] ny;

   function automatic logic [31:0] sx(input logic [15:0] v);
      sx = {{16{v[15]}}, v};
   endfunction

   assign sa = swap_ff ? 2'd2 : 2'd1;
   assign sb = swap_ff ? 2'd1 : 2'd2;
   assign sc = swap_ff ? 2'd3 : 2'd0;
   assign v1x = sx(vok_ff[1] ? vx_ff[1] : 16'd0);
   assign v1z = sx(vok_ff[1] ? vz_ff[1] : 16'd0);
   assign ny  = hsup_pkg::norm8(nrm_ff[19:10]);
   assign num = acc_ff + prod_ff;
   assign hgt = quo + sx(vok_ff[1] ? vy1_ff : 16'd0);

   // vertex of a slot, zero when the slot is beyond depth
   function automatic logic [31:0] vc(input logic [15:0] v, input logic ok);
      vc = ok ? sx(v) : 32'd0;
   endfunction

   // operand pair selection for the shared multiplier
   always_comb begin
      ax = vc(vx_ff[sa], vok_ff[sa]);
      az = vc(vz_ff[sa], vok_ff[sa]);
      bx = vc(vx_ff[sb], vok_ff[sb]);
      bz = vc(vz_ff[sb], vok_ff[sb]);
      cx = vc(vx_ff[sc], vok_ff[sc]);
      cz = vc(vz_ff[sc], vok_ff[sc]);
      ma = '0;
      mb = '0;
      case (state_ff)
         S_O1A: begin ma = qx_ff - bx; mb = az - bz; end
         S_O1B: begin ma = qz_ff - bz; mb = ax - bx; end
         S_O2A: begin ma = qx_ff - cx; mb = az - cz; end
         S_O2B: begin ma = qz_ff - cz; mb = ax - cx; end
         S_O3A: begin ma = qx_ff - bx; mb = cz - bz; end
         S_O3B: begin ma = qz_ff - bz; mb = cx - bx; end
         S_NA:  begin ma = hsup_pkg::norm8(nrm_ff[9:0]); mb = v1x - qx_ff; end
         S_NB:  begin ma = hsup_pkg::norm8(nrm_ff[29:20]); mb = v1z - qz_ff; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   assign vsel = ind_ff[5*vi_ff[1:0] +: 5];
   assign rd_addr = vsel[AW-1:0];
   assign div_start = (state_ff == S_DIV);
   assign req_ready = (state_ff == S_IDLE) && !ov_ff;

   hsup_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(num), .divisor(ny), .done(div_done), .quotient(quo)
   );

   // vertex memory: one write and one read a cycle
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && !ov_ff &&
          req_cmd == hsup_pkg::CMD_LOAD && 32'(req_vertex_index) < VERTEX_DEPTH)
         mem[req_vertex_index[AW-1:0]] <=
            {req_coord_x[15:0], req_coord_y, req_coord_z[15:0]};
      rd_ff <= mem[rd_addr];
   end

   // sequencer and running state
   always_ff @(posedge clock) begin
      prod_ff <= ma * mb;
      if (reset) begin
         state_ff <= S_IDLE;
         qx_ff <= '0;
         qz_ff <= '0;
         best_ff <= hsup_pkg::HEIGHT_NONE;
         fnd_ff <= 1'b0;
         pos_ff <= '0;
         ord_ff <= '0;
         rsp_valid <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         // output register: load a waiting result, or drop one just taken
         if (ov_ff && (!rsp_valid || rsp_ready)) begin
            rsp_valid <= 1'b1;
            rsp_best_height <= ov_h;
            rsp_found <= ov_f;
            rsp_best_position <= ov_f ? ov_p : 8'd0;
            ov_ff <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  ind_ff <= req_polygon_indices;
                  nrm_ff <= req_normal_word;
                  last_ff <= req_last_polygon;
                  vi_ff <= '0;
                  case (req_cmd)
                     hsup_pkg::CMD_QUERY: begin
                        qx_ff <= req_coord_x;
                        qz_ff <= req_coord_z;
                        best_ff <= hsup_pkg::HEIGHT_NONE;
                        fnd_ff <= 1'b0;
                        pos_ff <= '0;
                        ord_ff <= '0;
                     end
                     hsup_pkg::CMD_POLY:
                        state_ff <= req_polygon_indices[hsup_pkg::SKIP_BIT] ?
                                    S_DONE : S_RD;
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_RD: begin
               vok_rd_ff <= 32'(vsel) < VERTEX_DEPTH;
               state_ff <= S_CAP;
            end
            S_CAP: begin
               vx_ff[vi_ff[1:0]] <= rd_ff[47:32];
               vz_ff[vi_ff[1:0]] <= rd_ff[15:0];
               vok_ff[vi_ff[1:0]] <= vok_rd_ff;
               if (vi_ff == 3'd1) vy1_ff <= rd_ff[31:16];
               swap_ff <= 1'b0;
               vi_ff <= vi_ff + 3'd1;
               state_ff <= (vi_ff == 3'd3) ? S_O1A : S_RD;
            end
            S_O1A: state_ff <= S_O1B;
            S_O1B: begin acc_ff <= prod_ff; state_ff <= S_DEC; end
            S_DEC: begin
               if ($signed(acc_ff - prod_ff) < 0) begin
                  if (ind_ff[hsup_pkg::TRI_BIT]) state_ff <= S_DONE;
                  else begin swap_ff <= 1'b1; state_ff <= S_O2A; end
               end else state_ff <= S_O2A;
            end
            S_O2A: state_ff <= S_O2B;
            S_O2B: begin acc_ff <= prod_ff; state_ff <= S_O3A; end
            S_O3A: begin
               state_ff <= ($signed(acc_ff - prod_ff) > 0) ? S_DONE : S_O3B;
            end
            S_O3B: begin acc_ff <= prod_ff; state_ff <= S_NA; end
            S_NA: begin
               if ($signed(acc_ff - prod_ff) > 0 || ny == 32'd0) state_ff <= S_DONE;
               else state_ff <= S_NB;
            end
            S_NB: begin acc_ff <= prod_ff; state_ff <= S_DIV; end
            S_DIV: state_ff <= S_WAIT;
            S_WAIT: begin
               if (div_done) begin
                  if ($signed(hgt) > $signed(best_ff)) begin
                     best_ff <= hgt;
                     fnd_ff <= 1'b1;
                     pos_ff <= ord_ff;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (ord_ff < CAP) ord_ff <= ord_ff + 8'd1;
               if (last_ff) begin
                  ov_ff <= 1'b1;
                  ov_h <= best_ff;
                  ov_f <= fnd_ff;
                  ov_p <= pos_ff;
                  best_ff <= hsup_pkg::HEIGHT_NONE;
                  fnd_ff <= 1'b0;
                  pos_ff <= '0;
                  ord_ff <= '0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== verif/hsup_tb_pkg.sv =====
// Request and response payload types shared by the surface height testbench and checker.
`timescale 1ns / 1ps
`default_nettype none
package hsup_tb_pkg;
   typedef struct packed {
      hsup_pkg::cmd_type  cmd;
      logic [4:0]         vertex_index;
      logic signed [31:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [31:0] coord_z;
      logic [31:0]        polygon_indices;
      logic [29:0]        normal_word;
      logic               last_polygon;
   } surface_req_type;

   typedef struct packed {
      logic signed [31:0] best_height;
      logic               found;
      logic [7:0]         best_position;
   } surface_rsp_type;
endpackage
`default_nettype wire

// ===== verif/hsup_checker.sv =====
// Checker: predicts the highest surface under the query point and compares responses.
`timescale 1ns / 1ps
`default_nettype none
module hsup_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  hsup_tb_pkg::surface_req_type req_data,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  hsup_tb_pkg::surface_rsp_type rsp_data,
   output int        fail_count,
   output int        pending
);
   localparam logic [7:0] OrdinalCap = 8'd255;

   logic [15:0] store_x [32];
   logic [15:0] store_y [32];
   logic [15:0] store_z [32];
   logic [31:0] point_x, point_z;
   logic signed [31:0] top_height;
   logic [7:0]  top_position;
   logic        top_found;
   logic [7:0]  ordinal;
   hsup_tb_pkg::surface_rsp_type expected_heights [$];

   function automatic logic [31:0] vx(input logic [4:0] s);
      return {{16{store_x[s][15]}}, store_x[s]};
   endfunction
   function automatic logic [31:0] vy(input logic [4:0] s);
      return {{16{store_y[s][15]}}, store_y[s]};
   endfunction
   function automatic logic [31:0] vz(input logic [4:0] s);
      return {{16{store_z[s][15]}}, store_z[s]};
   endfunction

   // wrapping 32-bit XZ cross product of (P-B) and (A-B)
   function automatic logic signed [31:0] orient(input logic [4:0] a, input logic [4:0] b);
      logic [31:0] r;
      r = (point_x - vx(b)) * (vz(a) - vz(b)) - (point_z - vz(b)) * (vx(a) - vx(b));
      return $signed(r);
   endfunction

   // containment and plane height for one polygon; updates the running maximum
   task automatic try_polygon(input logic [31:0] ind, input logic [29:0] nrm);
      logic [4:0] s0, s1, s2, s3, sa, sb, sc;
      logic [31:0] nx, ny, nz, num;
      logic signed [31:0] q, h;
      if (ind[hsup_pkg::SKIP_BIT]) return;
      s0 = ind[4:0];
      s1 = ind[9:5];
      s2 = ind[14:10];
      s3 = ind[19:15];
      sa = s1;
      sb = s2;
      sc = s0;
      if (orient(s1, s2) < 0) begin
         if (ind[hsup_pkg::TRI_BIT]) return;
         sa = s2;
         sb = s1;
         sc = s3;
      end
      if (orient(sa, sc) > 0) return;
      if (orient(sc, sb) > 0) return;
      nx = {{19{nrm[9]}}, nrm[9:0], 3'b000};
      ny = {{19{nrm[19]}}, nrm[19:10], 3'b000};
      nz = {{19{nrm[29]}}, nrm[29:20], 3'b000};
      if (ny == 0) return;
      num = nx * (vx(s1) - point_x) + nz * (vz(s1) - point_z);
      q = $signed(num) / $signed(ny);
      h = q + $signed(vy(s1));
      if (h > top_height) begin
         top_height = h;
         top_found = 1'b1;
         top_position = ordinal;
      end
   endtask

   task automatic clear_running();
      top_height = hsup_pkg::HEIGHT_NONE;
      top_found = 1'b0;
      top_position = '0;
      ordinal = '0;
   endtask

   task automatic apply_request(input hsup_tb_pkg::surface_req_type r);
      hsup_tb_pkg::surface_rsp_type e;
      case (r.cmd)
         hsup_pkg::CMD_LOAD: begin
            store_x[r.vertex_index] = r.coord_x[15:0];
            store_y[r.vertex_index] = r.coord_y;
            store_z[r.vertex_index] = r.coord_z[15:0];
         end
         hsup_pkg::CMD_QUERY: begin
            point_x = r.coord_x;
            point_z = r.coord_z;
            clear_running();
         end
         hsup_pkg::CMD_POLY: begin
            try_polygon(r.polygon_indices, r.normal_word);
            if (ordinal < OrdinalCap) ordinal = ordinal + 8'd1;
            if (r.last_polygon) begin
               e.best_height = top_height;
               e.found = top_found;
               e.best_position = top_found ? top_position : 8'd0;
               expected_heights.push_back(e);
               clear_running();
            end
         end
         default: ;
      endcase
   endtask

   // watch both channels on each rising edge
   always @(posedge clock) begin
      hsup_tb_pkg::surface_rsp_type e;
      if (reset) begin
         for (int i = 0; i < 32; i++) begin
            store_x[i] = '0;
            store_y[i] = '0;
            store_z[i] = '0;
         end
         point_x = '0;
         point_z = '0;
         clear_running();
         expected_heights.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_heights.size() == 0) begin
               $error("response with no expectation waiting: height %0d", rsp_data.best_height);
               fail_count = fail_count + 1;
            end else begin
               e = expected_heights.pop_front();
               if (rsp_data.best_height !== e.best_height) begin
                  $error("best_height: expected %0d, got %0d", e.best_height,
                         rsp_data.best_height);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.found !== e.found) begin
                  $error("found: expected %0d, got %0d", e.found, rsp_data.found);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.best_position !== e.best_position) begin
                  $error("best_position: expected %0d, got %0d", e.best_position,
                         rsp_data.best_position);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) apply_request(req_data);
      end
      pending = expected_heights.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench top: request stimulus, response stalls, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   localparam int RandomRequests = 1550;
   localparam int WatchdogLimit = 20000;

   logic clock;
   logic reset;
   int   fail_count, pending;
   int   idle_pct, stall_pct;
   int   quiet_cycles;
   int   sent;

   hsup_if #(.payload_type(hsup_tb_pkg::surface_req_type)) req_ch ();
   hsup_if #(.payload_type(hsup_tb_pkg::surface_rsp_type)) rsp_ch ();

   highest_surface_under_point DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_cmd(req_ch.data.cmd),
      .req_vertex_index(req_ch.data.vertex_index),
      .req_coord_x(req_ch.data.coord_x),
      .req_coord_y(req_ch.data.coord_y),
      .req_coord_z(req_ch.data.coord_z),
      .req_polygon_indices(req_ch.data.polygon_indices),
      .req_normal_word(req_ch.data.normal_word),
      .req_last_polygon(req_ch.data.last_polygon),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_best_height(rsp_ch.data.best_height),
      .rsp_found(rsp_ch.data.found),
      .rsp_best_position(rsp_ch.data.best_position)
   );

   hsup_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_data(rsp_ch.data),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog: cycles without any accepted request or response
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one request, with random sender gaps, until accepted
   task automatic send(input hsup_tb_pkg::surface_req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (r.cmd != hsup_pkg::CMD_NONE) sent++;
   endtask

   function automatic hsup_tb_pkg::surface_req_type blank();
      hsup_tb_pkg::surface_req_type r;
      r = '0;
      r.cmd = hsup_pkg::CMD_NONE;
      r.coord_x = $urandom();
      r.coord_y = 16'($urandom());
      r.coord_z = $urandom();
      r.vertex_index = 5'($urandom());
      r.polygon_indices = $urandom();
      r.normal_word = 30'($urandom());
      r.last_polygon = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic load(input logic [4:0] s, input int x, input int y, input int z);
      hsup_tb_pkg::surface_req_type r;
      r = blank();
      r.cmd = hsup_pkg::CMD_LOAD;
      r.vertex_index = s;
      r.coord_x = {r.coord_x[31:16], x[15:0]};
      r.coord_y = y[15:0];
      r.coord_z = {r.coord_z[31:16], z[15:0]};
      send(r);
   endtask

   task automatic query(input int x, input int z);
      hsup_tb_pkg::surface_req_type r;
      r = blank();
      r.cmd = hsup_pkg::CMD_QUERY;
      r.coord_x = x;
      r.coord_z = z;
      send(r);
   endtask

   task automatic polygon(input logic [31:0] ind, input logic [29:0] nrm, input logic last);
      hsup_tb_pkg::surface_req_type r;
      r = blank();
      r.cmd = hsup_pkg::CMD_POLY;
      r.polygon_indices = ind;
      r.normal_word = nrm;
      r.last_polygon = last;
      send(r);
   endtask

   function automatic logic [31:0] quad_word(int a, int b, int c, int d, bit is_tri);
      logic [31:0] w;
      w = '0;
      w[4:0] = 5'(a);
      w[9:5] = 5'(b);
      w[14:10] = 5'(c);
      w[19:15] = 5'(d);
      w[hsup_pkg::TRI_BIT] = is_tri;
      return w;
   endfunction

   // random polygon word with noise in the unused bits
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom();
      w[hsup_pkg::SKIP_BIT] = ($urandom_range(9) == 0);
      return w;
   endfunction

   function automatic logic [29:0] random_normal();
      logic [29:0] n;
      n = 30'($urandom());
      if ($urandom_range(6) == 0) n[19:10] = '0;
      return n;
   endfunction

   function automatic int small_coord();
      return $signed($urandom_range(300)) - 150;
   endfunction

   initial begin
      int list_len;
      bit pressed, long_done;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      sent = 0;
      pressed = 0;
      long_done = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill every slot so no polygon reads an unwritten vertex
      for (int i = 0; i < 32; i++) load(5'(i), small_coord(), $urandom(), small_coord());

      // directed: square on slots 0..3, extremes on 4..5
      load(0, -100, 10, -100);
      load(1, 100, 20, -100);
      load(2, 100, 30, 100);
      load(3, -100, 40, 100);
      load(4, 32767, 32767, -32768);
      load(5, -32768, -32768, 32767);
      polygon(quad_word(0, 1, 2, 3, 0), 30'h0040_0400, 1'b1);  // no query yet
      query(0, 0);
      polygon(quad_word(0, 1, 2, 3, 1), 30'h0000_0400, 1'b0);  // triangle, one winding
      polygon(quad_word(0, 3, 2, 1, 1), 30'h0000_0400, 1'b0);  // opposite winding
      polygon(quad_word(2, 1, 3, 0, 0), 30'h1ff7_fdff, 1'b0);  // quad, alternate path
      polygon(quad_word(0, 1, 2, 3, 0), 30'h3ff0_03ff, 1'b0);  // vertical normal zero
      polygon(quad_word(0, 1, 2, 3, 0) | (32'd1 << hsup_pkg::SKIP_BIT), 30'h0000_0400,
              1'b1);
      query(32'h8000_0000, 32'h7fff_ffff);
      polygon(quad_word(4, 5, 4, 5, 0), 30'h2008_0200, 1'b0);
      polygon(32'hffff_ffff & ~(32'd1 << hsup_pkg::SKIP_BIT), 30'h3fff_ffff, 1'b1);
      polygon(32'hffff_ffff, 30'h0000_0000, 1'b1);           // skipped and last
      send(blank());                                        // unused command
      query(-7, 3);
      polygon(quad_word(3, 2, 1, 0, 0), 30'h1004_0100, 1'b1);

      // random lists of polygons around small queries
      while (sent < RandomRequests - 50) begin
         case ((sent / 380) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 27; stall_pct = 27; end
         endcase
         if (!pressed && sent > 800) begin
            pressed = 1;
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         repeat ($urandom_range(3)) begin
            if ($urandom_range(7) == 0)
               load(5'($urandom()), $urandom(), $urandom(), $urandom());
            else load(5'($urandom()), small_coord(), $urandom(), small_coord());
         end
         if ($urandom_range(4) == 0) query($urandom(), $urandom());
         else query(small_coord(), small_coord());
         if (!long_done && sent > 1200) begin
            long_done = 1;
            list_len = 270;
         end else begin
            list_len = $urandom_range(1, 8);
         end
         for (int i = 0; i < list_len; i++) begin
            if ($urandom_range(29) == 0) send(blank());
            polygon(random_word(), random_normal(), i == list_len - 1);
         end
         // occasional broken list: query restarts before a last polygon
         if ($urandom_range(9) == 0) polygon(random_word(), random_normal(), 1'b0);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
src/hsup_pkg.sv
src/hsup_if.sv
src/hsup_divider.sv
src/highest_surface_under_point.sv
verif/hsup_tb_pkg.sv
verif/hsup_checker.sv
verif/tb.sv
